// ===== rtl/srtc_pkg.sv =====
// Shared types and fixed constants of the sensor readout timing calculator.
package srtc_pkg;

	typedef logic [31:0] word_t;
	typedef logic [23:0] cnt24_t;
	typedef logic [15:0] half_t;

	localparam half_t  EXPO_MAX     = 16'd60000;
	localparam word_t  TICKS_PER_MS = 32'd24000;
	localparam word_t  PRE_BLANK    = 32'd369;
	localparam word_t  RESET_ROWS   = 32'd1538;
	localparam word_t  RESET_OFFSET = 32'd3997158 - 32'd369 - 32'd316 - 32'd12;
	localparam word_t  VB_BASE      = 32'd25;
	localparam word_t  VB_MARGIN    = 32'd10;
	localparam word_t  XFER_MASK    = 32'h0000_01FF;
	localparam half_t  EVEN_MASK    = 16'hFFFE;
	localparam half_t  COL_SKIP     = 16'h0020;
	localparam half_t  ROW_SKIP     = 16'h0014;

	// Reciprocal of 375 scaled by 2^35; applied to the frame total shifted right
	// by six, the top bits of the product give the frame total over 24000.
	localparam logic [26:0] MS_RECIP = 27'd91625969;

	// Payload that waits beside the shutter divider.
	typedef struct packed {
		logic   status;
		half_t  expo;
		half_t  cs;
		half_t  rs;
		half_t  ww;
		half_t  hw;
		word_t  tw;
		word_t  th;
		word_t  fsz;
		word_t  fms;
		word_t  rst;
		cnt24_t pre;
		cnt24_t frm;
		cnt24_t post;
	} stage_a_t;

	// Payload that waits beside the reset modulo divider.
	typedef struct packed {
		logic   status;
		half_t  expo;
		half_t  shut;
		half_t  cs;
		half_t  rs;
		half_t  ww;
		half_t  hw;
		word_t  fsz;
		cnt24_t pre;
		cnt24_t frm;
		cnt24_t post;
	} stage_b_t;

endpackage

// ===== rtl/sensor_readout_timing_calc.sv =====
// Top level of the sensor readout timing calculator pipeline.
//
// One window request is taken on any cycle that start is high; busy is always
// low, so a new request may follow in every cycle. Each request yields one
// result, shown for exactly one cycle with done high, after passing through
// three front stages, a 32-stage shutter divider, one stage to settle the
// shutter choice, a 32-stage modulo divider for the reset count and one output
// register. Results come out in request order and the receiver cannot hold
// them off. A window that overruns the sensor gives status 1 with every other
// field zero.
module sensor_readout_timing_calc
	import srtc_pkg::*;
#(
	parameter int SENSOR_COLS = 2048,
	parameter int SENSOR_ROWS = 1536
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [15:0] exposure_ms,
	input  logic [11:0] win_width,
	input  logic [10:0] win_height,
	input  logic [10:0] col_offset,
	input  logic [10:0] row_offset,
	input  logic [15:0] line_blank,
	input  logic [15:0] frame_blank,
	output logic        done,
	output logic        status,
	output logic [15:0] exposure_left,
	output logic [15:0] shutter_rows,
	output logic [15:0] col_start,
	output logic [15:0] row_start,
	output logic [15:0] width_word,
	output logic [15:0] height_word,
	output logic [23:0] pre_bytes,
	output logic [23:0] frame_bytes,
	output logic [23:0] post_bytes,
	output logic [23:0] reset_bytes
);

	localparam int DW = 32;
	localparam word_t COLS_W = word_t'(SENSOR_COLS);
	localparam word_t ROWS_W = word_t'(SENSOR_ROWS);

	// The pipeline never stalls, so a transaction is accepted whenever start is high.
	assign busy = 1'b0;

	// Stage 1: registered request.
	logic        vld_s1;
	logic [15:0] expo_s1, hb_s1, vb_s1;
	logic [11:0] w_s1;
	logic [10:0] h_s1, x_s1, y_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		expo_s1 <= exposure_ms;
		w_s1    <= win_width;
		h_s1    <= win_height;
		x_s1    <= col_offset;
		y_s1    <= row_offset;
		hb_s1   <= line_blank;
		vb_s1   <= frame_blank;
	end

	// Stage 1 logic: clamp, bounds check, window words and totals.
	half_t expo_c, ww_c, hw_c, cs_c, rs_c;
	word_t tw_c, th_c;
	logic  oob_c;

	always_comb begin
		expo_c = (expo_s1 > EXPO_MAX) ? EXPO_MAX : expo_s1;
		oob_c  = (word_t'(w_s1) + word_t'(x_s1) > COLS_W) ||
		         (word_t'(h_s1) + word_t'(y_s1) > ROWS_W);
		ww_c   = ((half_t'(w_s1) - 16'd1) & EVEN_MASK) + 16'd1;
		hw_c   = ((half_t'(h_s1) - 16'd1) & EVEN_MASK) + 16'd1;
		cs_c   = (half_t'(x_s1) & EVEN_MASK) + COL_SKIP;
		rs_c   = half_t'(y_s1) + ROW_SKIP;
		tw_c   = word_t'(ww_c) + 32'd3 + word_t'(hb_s1) + PRE_BLANK;
		th_c   = word_t'(hw_c) + 32'd1 + word_t'(vb_s1) + 32'd1;
	end

	logic        vld_s2, oob_s2;
	half_t       expo_s2, ww_s2, hw_s2, cs_s2, rs_s2, vb_s2;
	logic [10:0] h_s2;
	word_t       tw_s2, th_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		oob_s2  <= oob_c;
		expo_s2 <= expo_c;
		ww_s2   <= ww_c;
		hw_s2   <= hw_c;
		cs_s2   <= cs_c;
		rs_s2   <= rs_c;
		vb_s2   <= vb_s1;
		h_s2    <= h_s1;
		tw_s2   <= tw_c;
		th_s2   <= th_c;
	end

	// Stage 2 logic: the independent products, one multiplier each.
	word_t vbx_c, fsz_c, pre_c, frm_c, m1_c, m2_c, m3_c, ediv_c, cspan_c;

	always_comb begin
		vbx_c   = word_t'(vb_s2) - VB_BASE;
		cspan_c = COLS_W - (word_t'(ww_s2) + 32'd1);
		fsz_c   = tw_s2 * th_s2;
		pre_c   = word_t'(vb_s2) * tw_s2;
		frm_c   = tw_s2 * word_t'(h_s2);
		m1_c    = (RESET_ROWS - (vbx_c << 1) - (word_t'(hw_s2) + 32'd1)) * tw_s2;
		m2_c    = cspan_c * (th_s2 - vbx_c + VB_MARGIN);
		m3_c    = cspan_c * (ROWS_W - (word_t'(hw_s2) + 32'd1));
		ediv_c  = word_t'(expo_s2) * TICKS_PER_MS;
	end

	logic  vld_s3, oob_s3;
	half_t expo_s3, ww_s3, hw_s3, cs_s3, rs_s3;
	word_t tw_s3, th_s3, fsz_s3, pre_s3, frm_s3, m1_s3, m2_s3, m3_s3, ediv_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		oob_s3  <= oob_s2;
		expo_s3 <= expo_s2;
		ww_s3   <= ww_s2;
		hw_s3   <= hw_s2;
		cs_s3   <= cs_s2;
		rs_s3   <= rs_s2;
		tw_s3   <= tw_s2;
		th_s3   <= th_s2;
		fsz_s3  <= fsz_c;
		pre_s3  <= pre_c;
		frm_s3  <= frm_c;
		m1_s3   <= m1_c;
		m2_s3   <= m2_c;
		m3_s3   <= m3_c;
		ediv_s3 <= ediv_c;
	end

	// Stage 3 logic: sum the reset terms, round the frame to 512 bytes, form post,
	// and take the frame time in milliseconds by a reciprocal multiply.
	stage_a_t    pa_c, pa_d;
	word_t       frmr_c;
	logic [52:0] msprod_c;

	always_comb begin
		frmr_c      = (frm_s3 + XFER_MASK) & ~XFER_MASK;
		msprod_c    = 53'(fsz_s3[31:6]) * 53'(MS_RECIP);
		pa_c.status = oob_s3;
		pa_c.expo   = expo_s3;
		pa_c.cs     = cs_s3;
		pa_c.rs     = rs_s3;
		pa_c.ww     = ww_s3;
		pa_c.hw     = hw_s3;
		pa_c.tw     = tw_s3;
		pa_c.th     = th_s3;
		pa_c.fsz    = fsz_s3;
		pa_c.fms    = word_t'(msprod_c[52:35]);
		pa_c.rst    = m1_s3 + m2_s3 + m3_s3;
		pa_c.pre    = pre_s3[23:0];
		pa_c.frm    = frmr_c[23:0];
		pa_c.post   = fsz_s3[23:0] - pre_s3[23:0] - frmr_c[23:0];
	end

	// Row shutter quotient; the payload, frame time included, waits beside it.
	logic  vld_a;
	word_t shq;

	srtc_div #(.W(DW)) u_div_shut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s3),
		.dividend  (ediv_s3),
		.divisor   (tw_s3),
		.out_valid (vld_a),
		.quotient  (shq),
		.remainder ()
	);

	logic pa_vld;

	srtc_delay #(.W($bits(stage_a_t)), .DEPTH(DW)) u_dly_a (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s3),
		.in_data   (pa_c),
		.out_valid (pa_vld),
		.out_data  (pa_d)
	);

	// Stage 4 logic: rolling shutter when the frame alone is shorter than the
	// exposure, otherwise a row shutter of at least one row that also feeds the
	// reset count.
	stage_b_t pb_c;
	word_t    rst_c;
	half_t    sh_c;

	always_comb begin
		pb_c        = '0;
		pb_c.status = pa_d.status;
		pb_c.cs     = pa_d.cs;
		pb_c.rs     = pa_d.rs;
		pb_c.ww     = pa_d.ww;
		pb_c.hw     = pa_d.hw;
		pb_c.fsz    = pa_d.fsz;
		pb_c.pre    = pa_d.pre;
		pb_c.frm    = pa_d.frm;
		pb_c.post   = pa_d.post;
		sh_c        = (shq[15:0] == 16'd0) ? 16'd1 : shq[15:0];
		if (pa_d.fms < word_t'(pa_d.expo)) begin
			pb_c.shut = half_t'(pa_d.th - 32'd1);
			pb_c.expo = pa_d.expo - pa_d.fms[15:0];
			rst_c     = pa_d.rst;
		end else begin
			pb_c.shut = sh_c;
			pb_c.expo = 16'd0;
			rst_c     = pa_d.rst + (word_t'(sh_c) + 32'd1) * pa_d.tw;
		end
	end

	logic     vld_s4;
	stage_b_t pb_s4;
	word_t    rst_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else begin
			vld_s4 <= pa_vld & vld_a;
		end
	end

	always_ff @(posedge clk) begin
		pb_s4  <= pb_c;
		rst_s4 <= rst_c;
	end

	// Reset count modulo the frame total; with a zero divisor the remainder
	// equals the dividend, which is the skip the frame-total-zero case needs.
	logic     vld_b, pb_vld;
	word_t    rmod;
	stage_b_t pb_d;

	srtc_div #(.W(DW)) u_div_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s4),
		.dividend  (rst_s4),
		.divisor   (pb_s4.fsz),
		.out_valid (vld_b),
		.quotient  (),
		.remainder (rmod)
	);

	srtc_delay #(.W($bits(stage_b_t)), .DEPTH(DW)) u_dly_b (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s4),
		.in_data   (pb_s4),
		.out_valid (pb_vld),
		.out_data  (pb_d)
	);

	// Stage 5: final reset offset and the output register; an out-of-bounds
	// window clears every field but status.
	word_t rfin_c;
	logic  vld_s5, status_s5;
	half_t expo_s5, shut_s5, cs_s5, rs_s5, ww_s5, hw_s5;
	cnt24_t pre_s5, frm_s5, post_s5, rst_s5;
	logic  ok_c;

	assign rfin_c = rmod + RESET_OFFSET + pb_d.fsz;
	assign ok_c   = ~pb_d.status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else begin
			vld_s5 <= pb_vld & vld_b;
		end
	end

	always_ff @(posedge clk) begin
		status_s5 <= pb_d.status;
		expo_s5   <= ok_c ? pb_d.expo : 16'd0;
		shut_s5   <= ok_c ? pb_d.shut : 16'd0;
		cs_s5     <= ok_c ? pb_d.cs   : 16'd0;
		rs_s5     <= ok_c ? pb_d.rs   : 16'd0;
		ww_s5     <= ok_c ? pb_d.ww   : 16'd0;
		hw_s5     <= ok_c ? pb_d.hw   : 16'd0;
		pre_s5    <= ok_c ? pb_d.pre  : 24'd0;
		frm_s5    <= ok_c ? pb_d.frm  : 24'd0;
		post_s5   <= ok_c ? pb_d.post : 24'd0;
		rst_s5    <= ok_c ? rfin_c[23:0] : 24'd0;
	end

	assign done          = vld_s5;
	assign status        = status_s5;
	assign exposure_left = expo_s5;
	assign shutter_rows  = shut_s5;
	assign col_start     = cs_s5;
	assign row_start     = rs_s5;
	assign width_word    = ww_s5;
	assign height_word   = hw_s5;
	assign pre_bytes     = pre_s5;
	assign frame_bytes   = frm_s5;
	assign post_bytes    = post_s5;
	assign reset_bytes   = rst_s5;

endmodule

// ===== rtl/srtc_div.sv =====
// Pipelined restoring divider, one quotient bit per register stage.
module srtc_div #(
	parameter int W = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	input  logic [W-1:0] dividend,
	input  logic [W-1:0] divisor,
	output logic         out_valid,
	output logic [W-1:0] quotient,
	output logic [W-1:0] remainder
);

	logic         vld_s [1:W];
	logic [W-1:0] rem_s [1:W];
	logic [W-1:0] num_s [1:W];
	logic [W-1:0] den_s [1:W];
	logic [W-1:0] quo_s [1:W];

	genvar i;
	generate
		for (i = 0; i < W; i++) begin : g_stage
			logic         vld_in;
			logic [W-1:0] rem_in, num_in, den_in, quo_in;
			logic [W:0]   shifted, diff;
			logic         ge;

			if (i == 0) begin : g_first
				assign vld_in = in_valid;
				assign rem_in = '0;
				assign num_in = dividend;
				assign den_in = divisor;
				assign quo_in = '0;
			end else begin : g_next
				assign vld_in = vld_s[i];
				assign rem_in = rem_s[i];
				assign num_in = num_s[i];
				assign den_in = den_s[i];
				assign quo_in = quo_s[i];
			end

			assign shifted = {rem_in, num_in[W-1]};
			assign diff    = shifted - {1'b0, den_in};
			assign ge      = ~diff[W];

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_s[i+1] <= 1'b0;
				end else begin
					vld_s[i+1] <= vld_in;
				end
			end

			always_ff @(posedge clk) begin
				rem_s[i+1] <= ge ? diff[W-1:0] : shifted[W-1:0];
				num_s[i+1] <= {num_in[W-2:0], 1'b0};
				den_s[i+1] <= den_in;
				quo_s[i+1] <= {quo_in[W-2:0], ge};
			end
		end
	endgenerate

	assign out_valid = vld_s[W];
	assign quotient  = quo_s[W];
	assign remainder = rem_s[W];

endmodule

// ===== rtl/srtc_delay.sv =====
// Valid-tagged delay line that keeps payload aligned with a divider.
module srtc_delay #(
	parameter int W     = 8,
	parameter int DEPTH = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	input  logic [W-1:0] in_data,
	output logic         out_valid,
	output logic [W-1:0] out_data
);

	logic         vld_s [0:DEPTH-1];
	logic [W-1:0] dat_s [0:DEPTH-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < DEPTH; k++) vld_s[k] <= 1'b0;
		end else begin
			vld_s[0] <= in_valid;
			for (int k = 1; k < DEPTH; k++) vld_s[k] <= vld_s[k-1];
		end
	end

	always_ff @(posedge clk) begin
		dat_s[0] <= in_data;
		for (int k = 1; k < DEPTH; k++) dat_s[k] <= dat_s[k-1];
	end

	assign out_valid = vld_s[DEPTH-1];
	assign out_data  = dat_s[DEPTH-1];

endmodule

// ===== verif/sensor_timing_checker.sv =====
// Checker that predicts sensor timing words from accepted requests and compares each result.
module sensor_timing_checker
	import srtc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [15:0] exposure_ms,
	input  logic [11:0] win_width,
	input  logic [10:0] win_height,
	input  logic [10:0] col_offset,
	input  logic [10:0] row_offset,
	input  logic [15:0] line_blank,
	input  logic [15:0] frame_blank,
	input  logic        done,
	input  logic        status,
	input  logic [15:0] exposure_left,
	input  logic [15:0] shutter_rows,
	input  logic [15:0] col_start,
	input  logic [15:0] row_start,
	input  logic [15:0] width_word,
	input  logic [15:0] height_word,
	input  logic [23:0] pre_bytes,
	input  logic [23:0] frame_bytes,
	input  logic [23:0] post_bytes,
	input  logic [23:0] reset_bytes,
	output int          fail_count,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic        st;
		logic [15:0] expo, shut, cs, rs, ww, hw;
		logic [23:0] pre, frm, post, rst;
	} timing_words_t;

	timing_words_t timing_q[$];

	// Computes the timing words of one request in 32-bit wrap arithmetic.
	function automatic timing_words_t calc_timing(logic [15:0] e_in, logic [11:0] w_in,
		logic [10:0] h_in, logic [10:0] x_in, logic [10:0] y_in, logic [15:0] hb_in,
		logic [15:0] vb_in);
		timing_words_t r;
		logic [31:0] expo, w, h, x, y, hb, vb, ww, hw, tw, th, fsz, vbx, rst, shut, frm;
		logic [31:0] quot;
		expo = e_in;
		w = w_in;
		h = h_in;
		x = x_in;
		y = y_in;
		hb = hb_in;
		vb = vb_in;
		r = '{default: '0};
		if (expo > 32'd60000) expo = 32'd60000;
		if (w + x > 32'd2048 || h + y > 32'd1536) begin
			r.st = 1'b1;
			return r;
		end
		ww = ((w - 1) & 32'hFFFE) + 1;
		hw = ((h - 1) & 32'hFFFE) + 1;
		tw = (ww + 3) + hb + 32'd369;
		th = (hw + 1) + vb + 1;
		fsz = tw * th;
		vbx = vb - 32'd25;
		rst = (32'd1538 - vbx * 2 - (hw + 1)) * tw
			+ (32'd2048 - (ww + 1)) * (th - vbx + 32'd10)
			+ (32'd2048 - (ww + 1)) * (32'd1536 - (hw + 1));
		quot = fsz / 32'd24000;
		if (quot < expo) begin
			shut = (th - 1) & 32'hFFFF;
			expo = expo - quot;
		end else begin
			shut = ((expo * 32'd24000) / tw) & 32'hFFFF;
			if (shut < 1) shut = 1;
			rst = rst + (shut + 1) * tw;
			expo = 0;
		end
		// A frame total that wraps to zero skips the modulo step.
		if (fsz != 0) rst = rst % fsz;
		rst = rst + (32'd3997158 - 32'd369 - 32'd316 - 32'd12) + fsz;
		frm = tw * h;
		if (frm[8:0] != 0) frm = frm + (32'h200 - frm[8:0]);
		r.expo = expo[15:0];
		r.shut = shut[15:0];
		r.cs = (x[15:0] & 16'hFFFE) + 16'h20;
		r.rs = y[15:0] + 16'h14;
		r.ww = ww[15:0];
		r.hw = hw[15:0];
		r.pre = 24'(vb * tw);
		r.frm = frm[23:0];
		r.post = 24'(fsz - vb * tw - frm);
		r.rst = rst[23:0];
		return r;
	endfunction

	initial fail_count = 0;
	assign pending = timing_q.size();

	always @(posedge clk) begin
		timing_words_t exp_w;
		int errs;
		errs = 0;
		if (arst_n && done) begin
			if (timing_q.size() == 0) begin
				$error("result with no request outstanding");
				errs++;
			end else begin
				exp_w = timing_q.pop_front();
				if (status !== exp_w.st) begin
					$error("status: expected %0d, got %0d", exp_w.st, status);
					errs++;
				end
				if (exposure_left !== exp_w.expo) begin
					$error("exposure_left: expected %0d, got %0d", exp_w.expo, exposure_left);
					errs++;
				end
				if (shutter_rows !== exp_w.shut) begin
					$error("shutter_rows: expected %0d, got %0d", exp_w.shut, shutter_rows);
					errs++;
				end
				if (col_start !== exp_w.cs) begin
					$error("col_start: expected %0d, got %0d", exp_w.cs, col_start);
					errs++;
				end
				if (row_start !== exp_w.rs) begin
					$error("row_start: expected %0d, got %0d", exp_w.rs, row_start);
					errs++;
				end
				if (width_word !== exp_w.ww) begin
					$error("width_word: expected %0d, got %0d", exp_w.ww, width_word);
					errs++;
				end
				if (height_word !== exp_w.hw) begin
					$error("height_word: expected %0d, got %0d", exp_w.hw, height_word);
					errs++;
				end
				if (pre_bytes !== exp_w.pre) begin
					$error("pre_bytes: expected %0d, got %0d", exp_w.pre, pre_bytes);
					errs++;
				end
				if (frame_bytes !== exp_w.frm) begin
					$error("frame_bytes: expected %0d, got %0d", exp_w.frm, frame_bytes);
					errs++;
				end
				if (post_bytes !== exp_w.post) begin
					$error("post_bytes: expected %0d, got %0d", exp_w.post, post_bytes);
					errs++;
				end
				if (reset_bytes !== exp_w.rst) begin
					$error("reset_bytes: expected %0d, got %0d", exp_w.rst, reset_bytes);
					errs++;
				end
			end
		end
		if (errs != 0)
			fail_count <= fail_count + errs;
		// Queue after popping so a result could never be matched against a request taken in the same cycle.
		if (arst_n && start && !busy)
			timing_q.push_back(calc_timing(exposure_ms, win_width, win_height, col_offset,
				row_offset, line_blank, frame_blank));
	end
endmodule

// ===== verif/tb_sensor_readout_timing_calc.sv =====
// Testbench top: drives window requests into the timing calculator and gives the verdict.
module tb_sensor_readout_timing_calc;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_REQS = 1800;
	localparam int DRAIN_CYCLES = 100;
	// No transaction for this long means the block has stalled.
	localparam int STALL_LIMIT = 2000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [15:0] exposure_ms = '0;
	logic [11:0] win_width = '0;
	logic [10:0] win_height = '0;
	logic [10:0] col_offset = '0;
	logic [10:0] row_offset = '0;
	logic [15:0] line_blank = '0;
	logic [15:0] frame_blank = '0;
	logic        done, status;
	logic [15:0] exposure_left, shutter_rows, col_start, row_start, width_word, height_word;
	logic [23:0] pre_bytes, frame_bytes, post_bytes, reset_bytes;
	int          fail_count, pending;
	int          idle_cycles = 0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	sensor_readout_timing_calc dut (.*);
	sensor_timing_checker checker_i (.*);

	// The watchdog restarts on every accepted request or result.
	always @(posedge clk) begin
		if ((start && !busy) || done || !arst_n) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Presents one request and holds it until the block accepts it.
	task automatic send_window(logic [15:0] e, logic [11:0] w, logic [10:0] h,
		logic [10:0] x, logic [10:0] y, logic [15:0] hb, logic [15:0] vb);
		start <= 1'b1;
		exposure_ms <= e;
		win_width <= w;
		win_height <= h;
		col_offset <= x;
		row_offset <= y;
		line_blank <= hb;
		frame_blank <= vb;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	// Gap between requests; start only drops when a gap really follows.
	task automatic maybe_pause(bit allow);
		int n;
		if (allow && $urandom_range(0, 3) == 0) begin
			n = $urandom_range(1, 11);
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// A random request, mostly within the sensor so that the timing path is exercised.
	task automatic send_random(bit allow_idle);
		logic [15:0] e, hb, vb;
		logic [11:0] w;
		logic [10:0] h, x, y;
		int sel;
		sel = $urandom_range(0, 9);
		e = (sel < 3) ? 16'($urandom_range(0, 200)) : 16'($urandom);
		hb = ($urandom_range(0, 2) == 0) ? 16'($urandom) : 16'($urandom_range(0, 600));
		vb = ($urandom_range(0, 2) == 0) ? 16'($urandom) : 16'($urandom_range(0, 60));
		if (sel == 0) begin
			// Fully random fields, often out of bounds.
			w = 12'($urandom);
			h = 11'($urandom);
			x = 11'($urandom);
			y = 11'($urandom);
		end else begin
			w = 12'($urandom_range(0, 2048));
			h = 11'($urandom_range(0, 1536));
			x = 11'($urandom_range(0, 2048 - w));
			y = 11'($urandom_range(0, 1536 - h));
		end
		send_window(e, w, h, x, y, hb, vb);
		maybe_pause(allow_idle);
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: bounds, exposure clamp, zero sizes, small blanks and shutter modes.
		send_window(16'd0, 12'd4, 11'd4, 11'd0, 11'd0, 16'd0, 16'd0);
		send_window(16'hFFFF, 12'd2048, 11'd1536, 11'd0, 11'd0, 16'hFFFF, 16'hFFFF);
		send_window(16'd60000, 12'd2048, 11'd1536, 11'd0, 11'd0, 16'd0, 16'd25);
		send_window(16'd60001, 12'd1024, 11'd768, 11'd1024, 11'd768, 16'd100, 16'd24);
		send_window(16'd100, 12'd2048, 11'd4, 11'd1, 11'd0, 16'd0, 16'd0);
		send_window(16'd100, 12'd4, 11'd1536, 11'd0, 11'd1, 16'd0, 16'd0);
		send_window(16'd5, 12'hFFF, 11'h7FF, 11'h7FF, 11'h7FF, 16'd0, 16'd0);
		send_window(16'd5, 12'd0, 11'd0, 11'd2047, 11'd1535, 16'd0, 16'd0);
		send_window(16'd50, 12'd0, 11'd100, 11'd3, 11'd5, 16'd10, 16'd30);
		send_window(16'd50, 12'd100, 11'd0, 11'd7, 11'd9, 16'd10, 16'd30);
		send_window(16'd1, 12'd5, 11'd5, 11'd1, 11'd1, 16'hFFFF, 16'd0);
		send_window(16'd0, 12'd640, 11'd480, 11'd1408, 11'd1056, 16'd0, 16'd1);
		send_window(16'd30000, 12'd640, 11'd480, 11'd100, 11'd100, 16'd0, 16'd1000);
		send_window(16'd2, 12'd4, 11'd4, 11'd0, 11'd0, 16'd0, 16'd26);
		send_window(16'd1000, 12'd1280, 11'd1024, 11'd769, 11'd513, 16'd500, 16'hFFFF);
		send_window(16'hFFFF, 12'd4, 11'd4, 11'd2044, 11'd1532, 16'hFFFF, 16'hFFFF);
		send_window(16'd7, 12'hFFF, 11'd4, 11'd0, 11'd0, 16'd0, 16'd0);

		for (int i = 0; i < RANDOM_REQS; i++)
			send_random(i < RANDOM_REQS - 200);
		start <= 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
